@@ rtl/core/crlpf_pkg.sv @@
// ----------------------------------------------------------------------------
// crlpf_pkg
// shared types and fixed constants of the loop path follower
// ----------------------------------------------------------------------------
package crlpf_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_POINT_ZERO  = 3'd0;
    localparam t_cfg_idx CFG_POINT_ONE   = 3'd1;
    localparam t_cfg_idx CFG_POINT_TWO   = 3'd2;
    localparam t_cfg_idx CFG_POINT_THREE = 3'd3;
    localparam t_cfg_idx CFG_SEG_TIME    = 3'd4;

    // register reset values
    localparam logic [CFG_DATA_W-1:0] RST_POINT_ZERO  = 32'd100726016;
    localparam logic [CFG_DATA_W-1:0] RST_POINT_ONE   = 32'd83948800;
    localparam logic [CFG_DATA_W-1:0] RST_POINT_TWO   = 32'd83949824;
    localparam logic [CFG_DATA_W-1:0] RST_POINT_THREE = 32'd100727040;
    localparam logic [CFG_DATA_W-1:0] RST_SEG_TIME    = 32'd1000;

    // fixed field widths
    localparam int PT_W   = 16;              // one point coordinate, signed q8.8
    localparam int FRAC_W = 16;              // t within segment, q0.16
    localparam int SEG_W  = 2;               // segment index
    localparam int QW     = SEG_W + FRAC_W;  // kept quotient bits
    localparam int CF_W   = 21;              // spline coefficient
    localparam int SW     = 22;              // horner accumulator

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_COEF,
        ST_MUL,
        ST_OUT
    } t_state;

endpackage

@@ rtl/core/catmull_rom_loop_path_follower_top.sv @@
// ----------------------------------------------------------------------------
// catmull_rom_loop_path_follower_top
// closed-loop uniform catmull-rom path follower over four control points
// ----------------------------------------------------------------------------
// Each input beat is one time tick. delta_time is added to the segment timer,
// whole segment times are removed and each one steps the segment index round
// the loop 0,1,2,3,0. The timer left over becomes t in q0.16 and a uniform
// catmull-rom cubic on the points around the index gives the position, which
// is saturated to COORD_WIDTH. One result beat per tick, carrying the
// position, the start point of the current segment as the facing target,
// the segment index and t. A single restoring divider, one bit per cycle,
// produces both the segment wrap count and t; ST_COEF then forms the
// coefficients and a single shared multiplier runs three horner steps per
// axis. The next tick is taken in the cycle after the result is loaded
// into the output register. A segment_time of zero acts as one.
// Configuration writes are always ready and must only be issued
// while no tick is in flight.
module catmull_rom_loop_path_follower_top
    import crlpf_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int TIME_WIDTH  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    // tick input
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [TIME_WIDTH-1:0]         i_delta_time,
    // result output
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [COORD_WIDTH-1:0] o_pos_x,
    output logic signed [COORD_WIDTH-1:0] o_pos_y,
    output logic signed [COORD_WIDTH-1:0] o_face_x,
    output logic signed [COORD_WIDTH-1:0] o_face_y,
    output logic [SEG_W-1:0]              o_segment,
    output logic [FRAC_W-1:0]             o_fraction
);

    // divider geometry: dividend is the new timer with sixteen zero bits below
    localparam int DW    = TIME_WIDTH + 1 + FRAC_W;
    localparam int CNT_W = $clog2(DW);
    localparam logic [CNT_W-1:0] CNT_REM  = CNT_W'(TIME_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DW - 1);

    // multiplier and clamp widths
    localparam int PW = SW + FRAC_W + 1;
    localparam int EW = (COORD_WIDTH > SW ? COORD_WIDTH : SW) + 1;
    localparam logic signed [EW-1:0] CLAMP_HI =
        signed'({{(EW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}});
    localparam logic signed [EW-1:0] CLAMP_LO = ~CLAMP_HI;
    localparam logic signed [SW-1:0] ACC_ONE  = SW'(1);

    function automatic logic [COORD_WIDTH-1:0] f_clamp(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] t;
        t = v;
        if (v > CLAMP_HI) t = CLAMP_HI;
        if (v < CLAMP_LO) t = CLAMP_LO;
        return t[COORD_WIDTH-1:0];
    endfunction

    // control and configuration state
    t_state                  r_state, n_state;
    logic [TIME_WIDTH:0]     r_elapsed, n_elapsed;
    logic [SEG_W-1:0]        r_seg_idx, n_seg_idx;
    logic [CFG_DATA_W-1:0]   r_pt0, n_pt0, r_pt1, n_pt1, r_pt2, n_pt2, r_pt3, n_pt3;
    logic [TIME_WIDTH-1:0]   r_seg_time, n_seg_time;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_axis, n_axis;
    logic [1:0]              r_step, n_step;
    logic                    r_o_valid, n_o_valid;

    // working registers
    logic [DW-1:0]           r_div, n_div;
    logic [TIME_WIDTH-1:0]   r_rem, n_rem;
    logic [QW-1:0]           r_q, n_q;
    logic [FRAC_W-1:0]       r_frac, n_frac;
    logic signed [SW-1:0]    r_acc, n_acc;
    logic signed [CF_W-1:0]  r_c2x, n_c2x, r_c1x, n_c1x, r_c0x, n_c0x;
    logic signed [CF_W-1:0]  r_c3y, n_c3y, r_c2y, n_c2y, r_c1y, n_c1y, r_c0y, n_c0y;
    logic [COORD_WIDTH-1:0]  r_px, n_px, r_py, n_py;
    logic [COORD_WIDTH-1:0]  r_fx, n_fx, r_fy, n_fy;

    // output register
    logic [COORD_WIDTH-1:0]  r_o_pos_x, r_o_pos_y, r_o_face_x, r_o_face_y;
    logic [SEG_W-1:0]        r_o_segment;
    logic [FRAC_W-1:0]       r_o_fraction;
    logic                    w_load;

    // shared divider step
    logic [TIME_WIDTH-1:0]   w_seg_eff;
    logic [TIME_WIDTH+1:0]   w_trial;
    logic                    w_ge;
    logic [TIME_WIDTH-1:0]   w_rem_next;
    logic [QW-1:0]           w_q_next;
    logic [TIME_WIDTH:0]     w_sum;

    assign w_seg_eff  = (r_seg_time == '0) ? TIME_WIDTH'(1) : r_seg_time;
    assign w_trial    = {1'b0, r_rem, r_div[DW-1]} - {2'b00, w_seg_eff};
    assign w_ge       = !w_trial[TIME_WIDTH+1];
    assign w_rem_next = w_ge ? w_trial[TIME_WIDTH-1:0]
                             : {r_rem[TIME_WIDTH-2:0], r_div[DW-1]};
    assign w_q_next   = {r_q[QW-2:0], w_ge};
    assign w_sum      = r_elapsed + {1'b0, i_delta_time};

    // rotate the loop so a,b,c,d are index-1 .. index+2
    logic [CFG_DATA_W-1:0]   w_pa, w_pb, w_pc, w_pd;

    always_comb begin
        case (r_seg_idx)
            2'd0: begin
                w_pa = r_pt3; w_pb = r_pt0; w_pc = r_pt1; w_pd = r_pt2;
            end
            2'd1: begin
                w_pa = r_pt0; w_pb = r_pt1; w_pc = r_pt2; w_pd = r_pt3;
            end
            2'd2: begin
                w_pa = r_pt1; w_pb = r_pt2; w_pc = r_pt3; w_pd = r_pt0;
            end
            default: begin
                w_pa = r_pt2; w_pb = r_pt3; w_pc = r_pt0; w_pd = r_pt1;
            end
        endcase
    end

    // coefficients for both axes, adds and shifts only
    logic signed [CF_W-1:0]  w_ax, w_bx, w_cx, w_dx, w_ay, w_by, w_cy, w_dy;
    logic signed [CF_W-1:0]  w_c3x, w_c2x, w_c1x, w_c0x;
    logic signed [CF_W-1:0]  w_c3y, w_c2y, w_c1y, w_c0y;

    assign w_ax = CF_W'(signed'(w_pa[2*PT_W-1:PT_W]));
    assign w_bx = CF_W'(signed'(w_pb[2*PT_W-1:PT_W]));
    assign w_cx = CF_W'(signed'(w_pc[2*PT_W-1:PT_W]));
    assign w_dx = CF_W'(signed'(w_pd[2*PT_W-1:PT_W]));
    assign w_ay = CF_W'(signed'(w_pa[PT_W-1:0]));
    assign w_by = CF_W'(signed'(w_pb[PT_W-1:0]));
    assign w_cy = CF_W'(signed'(w_pc[PT_W-1:0]));
    assign w_dy = CF_W'(signed'(w_pd[PT_W-1:0]));

    assign w_c3x = (w_dx - w_ax) + ((w_bx - w_cx) <<< 1) + (w_bx - w_cx);
    assign w_c2x = (w_ax <<< 1) - (w_bx <<< 2) - w_bx + (w_cx <<< 2) - w_dx;
    assign w_c1x = w_cx - w_ax;
    assign w_c0x = w_bx <<< 1;
    assign w_c3y = (w_dy - w_ay) + ((w_by - w_cy) <<< 1) + (w_by - w_cy);
    assign w_c2y = (w_ay <<< 1) - (w_by <<< 2) - w_by + (w_cy <<< 2) - w_dy;
    assign w_c1y = w_cy - w_ay;
    assign w_c0y = w_by <<< 1;

    // shared multiplier: one horner step, floor of s*u/2^16 plus next coefficient
    logic signed [CF_W-1:0]  w_coef;
    logic signed [PW-1:0]    w_prod;
    logic signed [PW-1:0]    w_shift;
    logic signed [SW-1:0]    w_horner;
    logic signed [SW-1:0]    w_round;

    always_comb begin
        case (r_step)
            2'd0:    w_coef = r_axis ? r_c2y : r_c2x;
            2'd1:    w_coef = r_axis ? r_c1y : r_c1x;
            default: w_coef = r_axis ? r_c0y : r_c0x;
        endcase
    end

    assign w_prod   = r_acc * $signed({1'b0, r_frac});
    assign w_shift  = w_prod >>> FRAC_W;
    assign w_horner = signed'(w_shift[SW-1:0]) + SW'(w_coef);
    // half rounds up
    assign w_round  = (w_horner + ACC_ONE) >>> 1;

    // sequencer, next state and datapath
    always_comb begin
        n_state    = r_state;
        n_elapsed  = r_elapsed;
        n_seg_idx  = r_seg_idx;
        n_pt0      = r_pt0;
        n_pt1      = r_pt1;
        n_pt2      = r_pt2;
        n_pt3      = r_pt3;
        n_seg_time = r_seg_time;
        n_cnt      = r_cnt;
        n_axis     = r_axis;
        n_step     = r_step;
        n_div      = r_div;
        n_rem      = r_rem;
        n_q        = r_q;
        n_frac     = r_frac;
        n_acc      = r_acc;
        n_c2x      = r_c2x;
        n_c1x      = r_c1x;
        n_c0x      = r_c0x;
        n_c3y      = r_c3y;
        n_c2y      = r_c2y;
        n_c1y      = r_c1y;
        n_c0y      = r_c0y;
        n_px       = r_px;
        n_py       = r_py;
        n_fx       = r_fx;
        n_fy       = r_fy;
        w_load     = 1'b0;
        n_o_valid  = r_o_valid && !i_ready;

        // configuration writes, indexes past the list are dropped
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_POINT_ZERO:  n_pt0      = i_cfg_data;
                CFG_POINT_ONE:   n_pt1      = i_cfg_data;
                CFG_POINT_TWO:   n_pt2      = i_cfg_data;
                CFG_POINT_THREE: n_pt3      = i_cfg_data;
                CFG_SEG_TIME:    n_seg_time = i_cfg_data[TIME_WIDTH-1:0];
                default: ;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_div   = {w_sum, {FRAC_W{1'b0}}};
                    n_rem   = '0;
                    n_q     = '0;
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_div = {r_div[DW-2:0], 1'b0};
                n_rem = w_rem_next;
                n_q   = w_q_next;
                // all timer bits consumed: the partial remainder is the new timer
                if (r_cnt == CNT_REM) begin
                    n_elapsed = {1'b0, w_rem_next};
                end
                if (r_cnt == CNT_LAST) begin
                    n_seg_idx = r_seg_idx + w_q_next[QW-1:FRAC_W];
                    n_frac    = w_q_next[FRAC_W-1:0];
                    n_state   = ST_COEF;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_COEF: begin
                n_acc   = SW'(w_c3x);
                n_c2x   = w_c2x;
                n_c1x   = w_c1x;
                n_c0x   = w_c0x;
                n_c3y   = w_c3y;
                n_c2y   = w_c2y;
                n_c1y   = w_c1y;
                n_c0y   = w_c0y;
                n_fx    = f_clamp(EW'(signed'(w_pb[2*PT_W-1:PT_W])));
                n_fy    = f_clamp(EW'(signed'(w_pb[PT_W-1:0])));
                n_axis  = 1'b0;
                n_step  = 2'd0;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_acc = w_horner;
                if (r_step == 2'd2) begin
                    n_step = 2'd0;
                    if (r_axis) begin
                        n_py    = f_clamp(EW'(w_round));
                        n_state = ST_OUT;
                    end else begin
                        n_px   = f_clamp(EW'(w_round));
                        n_acc  = SW'(r_c3y);
                        n_axis = 1'b1;
                    end
                end else begin
                    n_step = r_step + 2'd1;
                end
            end
            ST_OUT: begin
                // wait for the output register to free up
                if (!r_o_valid || i_ready) begin
                    w_load    = 1'b1;
                    n_o_valid = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_elapsed  <= '0;
            r_seg_idx  <= '0;
            r_pt0      <= RST_POINT_ZERO;
            r_pt1      <= RST_POINT_ONE;
            r_pt2      <= RST_POINT_TWO;
            r_pt3      <= RST_POINT_THREE;
            r_seg_time <= TIME_WIDTH'(RST_SEG_TIME);
            r_cnt      <= '0;
            r_axis     <= 1'b0;
            r_step     <= 2'd0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_elapsed  <= n_elapsed;
            r_seg_idx  <= n_seg_idx;
            r_pt0      <= n_pt0;
            r_pt1      <= n_pt1;
            r_pt2      <= n_pt2;
            r_pt3      <= n_pt3;
            r_seg_time <= n_seg_time;
            r_cnt      <= n_cnt;
            r_axis     <= n_axis;
            r_step     <= n_step;
            r_o_valid  <= n_o_valid;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_div  <= n_div;
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_frac <= n_frac;
        r_acc  <= n_acc;
        r_c2x  <= n_c2x;
        r_c1x  <= n_c1x;
        r_c0x  <= n_c0x;
        r_c3y  <= n_c3y;
        r_c2y  <= n_c2y;
        r_c1y  <= n_c1y;
        r_c0y  <= n_c0y;
        r_px   <= n_px;
        r_py   <= n_py;
        r_fx   <= n_fx;
        r_fy   <= n_fy;
        if (w_load) begin
            r_o_pos_x    <= r_px;
            r_o_pos_y    <= r_py;
            r_o_face_x   <= r_fx;
            r_o_face_y   <= r_fy;
            r_o_segment  <= r_seg_idx;
            r_o_fraction <= r_frac;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == ST_IDLE);
    assign o_valid     = r_o_valid;
    assign o_pos_x     = signed'(r_o_pos_x);
    assign o_pos_y     = signed'(r_o_pos_y);
    assign o_face_x    = signed'(r_o_face_x);
    assign o_face_y    = signed'(r_o_face_y);
    assign o_segment   = r_o_segment;
    assign o_fraction  = r_o_fraction;

endmodule

@@ rtl/core/crlpf_checker.sv @@
// ----------------------------------------------------------------------------
// crlpf_checker
// port-level checks of the loop path follower, bound to the top level
// ----------------------------------------------------------------------------
module crlpf_checker
    import crlpf_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int TIME_WIDTH  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          o_ready,
    input  logic [TIME_WIDTH-1:0]         i_delta_time,
    input  logic                          o_valid,
    input  logic                          i_ready,
    input  logic signed [COORD_WIDTH-1:0] o_pos_x,
    input  logic signed [COORD_WIDTH-1:0] o_pos_y,
    input  logic signed [COORD_WIDTH-1:0] o_face_x,
    input  logic signed [COORD_WIDTH-1:0] o_face_y,
    input  logic [SEG_W-1:0]              o_segment,
    input  logic [FRAC_W-1:0]             o_fraction
);

    // ticks taken but not yet delivered
    logic [1:0] r_pend;
    logic       w_in_beat;
    logic       w_out_beat;

    assign w_in_beat  = i_valid && o_ready;
    assign w_out_beat = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
        end else begin
            r_pend <= r_pend + {1'b0, w_in_beat} - {1'b0, w_out_beat};
        end
    end

    // after a tick the block stays busy and takes no new input straight away
    a_busy_after_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat |=> !o_ready ##1 !o_ready)
        else $error("input taken again too soon after a tick");

    // never a result without a tick behind it
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_pend != 2'd0))
        else $error("result beat with no tick pending");

    // at most one tick in work plus one result waiting
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3)
        else $error("too many ticks in flight");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pos_x) && $stable(o_pos_y)
            && $stable(o_face_x) && $stable(o_face_y)
            && $stable(o_segment) && $stable(o_fraction))
        else $error("stalled result changed");

    // a waiting tick holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_delta_time))
        else $error("waiting tick changed");

endmodule

bind catmull_rom_loop_path_follower_top crlpf_checker #(
    .COORD_WIDTH(COORD_WIDTH),
    .TIME_WIDTH (TIME_WIDTH)
) u_crlpf_checker (.*);
